// File: src/sei_pkg.sv
// Package for the sine ease interpolator: segment codes, register indexes,
// register reset values and the constant function behind the sine table.
// No dependencies.
`default_nettype none

package sei_pkg;

   // segment of the curve an item falls in; START and END bypass the math
   typedef enum logic [2:0] {
      SEG_START,
      SEG_END,
      SEG_IN,
      SEG_MID,
      SEG_OUT
   } seg_type;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_EASE_IN_END    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EASE_OUT_START = 1'b1;

   localparam logic [CSR_DATA_W-1:0] EASE_IN_END_RESET    = 17'd16384;
   localparam logic [CSR_DATA_W-1:0] EASE_OUT_START_RESET = 17'd49152;

   // sine table entries are sin(pi x)/pi in Q0.30, always below 2^29
   localparam int SINE_W = 30;

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint TAYLOR_DIVS [1:7] = '{6, 20, 42, 72, 110, 156, 210};

   // sin(pi * idx / 2^(tab_bits+1)) / pi, Q0.30, truncated at every step
   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                    input int unsigned tab_bits);
      longint th;
      longint sum;
      longint term;
      th   = (PI_Q30 * longint'(idx)) >>> (tab_bits + 1);
      sum  = th;
      term = th;
      for (int k = 1; k <= 7; k++) begin
         term = (term * th) >>> 30;
         term = (term * th) >>> 30;
         term = term / TAYLOR_DIVS[k];
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return SINE_W'((sum <<< 30) / PI_Q30);
   endfunction

endpackage

`default_nettype wire

// File: src/sine_ease_interpolator_top.sv
// Sine ease interpolator top level; uses sei_pkg, sei_div and sei_sine.
// Curve segment select, two pipelined dividers, sine lookup, final scaling.
`default_nettype none

// Eases from start_value to end_value as progress runs 0..1: sine ease-in,
// linear middle, sine ease-out, saturated to 32 bits. One item per clock
// while not held; stages: 1 select, two 31-stage dividers, 3 sine, 3
// numerator, 3 scaling. The whole pipeline holds while a result waits and
// rsp_ready is low. The ease points are written through the csr port; the
// user must write them only while the block is idle; the block does not
// enforce this. config_error reports an ease-in end past the ease-out start.

module sine_ease_interpolator_top #(
   parameter int FRAC_BITS       = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [16:0]                       req_progress,
   input  wire logic signed [31:0]                req_start_value,
   input  wire logic signed [31:0]                req_end_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [31:0]                     rsp_eased_value,
   output logic                                   rsp_config_error,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sei_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sei_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TW   = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
   localparam int DW   = TW + 1;
   localparam int N1_W = TW + 30;
   localparam int N2_W = TW + 32;
   localparam int P_W  = TW + 31;
   localparam int Q_W  = 31;
   localparam logic [TW-1:0] ONE    = TW'(1) << FRAC_BITS;
   localparam logic [30:0]   F_ONE  = 31'h4000_0000;
   localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

   typedef struct packed {
      sei_pkg::seg_type   seg;
      logic [TW-1:0]      t;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } ctx_type;

   localparam int CTX_W = $bits(ctx_type);

   // configuration
   logic [sei_pkg::CSR_DATA_W-1:0] ease_in_end_ff;
   logic [sei_pkg::CSR_DATA_W-1:0] ease_out_start_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_in_end_ff    <= sei_pkg::EASE_IN_END_RESET;
         ease_out_start_ff <= sei_pkg::EASE_OUT_START_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sei_pkg::CSR_EASE_IN_END:    ease_in_end_ff    <= csr_wdata;
            sei_pkg::CSR_EASE_OUT_START: ease_out_start_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective ease points; the user keeps them static while items are in flight, the block does not enforce it
   logic [TW-1:0] ein_raw;
   logic [TW-1:0] eout;
   logic [TW-1:0] ein;
   logic [TW-1:0] iout;
   logic [DW-1:0] ee;
   logic          cfg_err;

   assign ein_raw = (TW'(ease_in_end_ff) > ONE) ? ONE : TW'(ease_in_end_ff);
   assign eout    = (TW'(ease_out_start_ff) > ONE) ? ONE : TW'(ease_out_start_ff);
   assign cfg_err = ein_raw > eout;
   assign ein     = cfg_err ? eout : ein_raw;
   assign iout    = ONE - eout;
   assign ee      = DW'(eout) - DW'(ein) + DW'(ONE);

   assign rsp_config_error = cfg_err;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: clamp, pick segment, set up first division
   logic [TW-1:0]  t_in;
   ctx_type        s1_ctx_in;
   logic [N1_W-1:0] s1_num_in;
   logic [DW-1:0]   s1_den_in;

   always_comb begin
      t_in = (TW'(req_progress) > ONE) ? ONE : TW'(req_progress);
      s1_ctx_in.t = t_in;
      s1_ctx_in.a = req_start_value;
      s1_ctx_in.b = req_end_value;
      if (t_in == '0) begin
         s1_ctx_in.seg = sei_pkg::SEG_START;
      end else if (t_in == ONE) begin
         s1_ctx_in.seg = sei_pkg::SEG_END;
      end else if (t_in <= ein) begin
         s1_ctx_in.seg = sei_pkg::SEG_IN;
      end else if (t_in <= eout) begin
         s1_ctx_in.seg = sei_pkg::SEG_MID;
      end else begin
         s1_ctx_in.seg = sei_pkg::SEG_OUT;
      end
      if (s1_ctx_in.seg == sei_pkg::SEG_OUT) begin
         s1_num_in = N1_W'(t_in - eout) << 30;
         s1_den_in = DW'(iout);
      end else begin
         s1_num_in = N1_W'(t_in) << 30;
         s1_den_in = DW'(ein);
      end
   end

   logic            s1_valid_ff;
   ctx_type         s1_ctx_ff;
   logic [N1_W-1:0] s1_num_ff;
   logic [DW-1:0]   s1_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_num_ff <= s1_num_in;
         s1_den_ff <= s1_den_in;
      end
   end

   // v = t/ein or w = (t-eout)/iout
   logic             d1_valid;
   logic [Q_W-1:0]   d1_quot;
   logic [CTX_W-1:0] d1_side;

   sei_div #(
      .NUM_W  (N1_W),
      .DEN_W  (DW),
      .Q_W    (Q_W),
      .SIDE_W (CTX_W)
   ) u_div_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .in_side   (s1_ctx_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   logic                       sn_valid;
   logic [30:0]                sn_u;
   logic [sei_pkg::SINE_W-1:0] sn_sin;
   logic [CTX_W-1:0]           sn_side;

   sei_sine #(
      .TABLE_BITS (SINE_TABLE_BITS),
      .SIDE_W     (CTX_W)
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_u      (d1_quot),
      .in_side   (d1_side),
      .out_valid (sn_valid),
      .out_u     (sn_u),
      .out_sin   (sn_sin),
      .out_side  (sn_side)
   );

   // P0: g = v - sin/pi (floored at 0) or h = w + sin/pi
   ctx_type     sn_ctx;
   logic [31:0] g_diff;
   logic [30:0] p0_op_in;

   assign sn_ctx   = ctx_type'(sn_side);
   assign g_diff   = {1'b0, sn_u} - {2'b0, sn_sin};
   assign p0_op_in = (sn_ctx.seg == sei_pkg::SEG_IN) ?
                     (g_diff[31] ? '0 : g_diff[30:0]) :
                     sn_u + 31'(sn_sin);

   logic        p0_valid_ff;
   ctx_type     p0_ctx_ff;
   logic [30:0] p0_op_ff;

   // P1: scale by the segment length
   logic [TW-1:0]  p1_mult;
   logic [P_W-1:0] p1_prod_in;

   assign p1_mult    = (p0_ctx_ff.seg == sei_pkg::SEG_IN) ? ein : iout;
   assign p1_prod_in = p0_op_ff * p1_mult;

   logic           p1_valid_ff;
   ctx_type        p1_ctx_ff;
   logic [P_W-1:0] p1_prod_ff;

   // P2: numerator of the final fraction
   logic [N2_W-1:0] p2_num_in;

   always_comb begin
      case (p1_ctx_ff.seg)
         sei_pkg::SEG_IN:  p2_num_in = N2_W'(p1_prod_ff);
         sei_pkg::SEG_MID: p2_num_in = ((N2_W'(p1_ctx_ff.t) << 1) - N2_W'(ein)) << 30;
         sei_pkg::SEG_OUT: p2_num_in = N2_W'(p1_prod_ff) +
                                       (((N2_W'(eout) << 1) - N2_W'(ein)) << 30);
         default:          p2_num_in = '0;
      endcase
   end

   logic            p2_valid_ff;
   ctx_type         p2_ctx_ff;
   logic [N2_W-1:0] p2_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= sn_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ctx_ff  <= sn_ctx;
         p0_op_ff   <= p0_op_in;
         p1_ctx_ff  <= p0_ctx_ff;
         p1_prod_ff <= p1_prod_in;
         p2_ctx_ff  <= p1_ctx_ff;
         p2_num_ff  <= p2_num_in;
      end
   end

   // F = numerator / ee
   logic             d2_valid;
   logic [Q_W-1:0]   d2_quot;
   logic [CTX_W-1:0] d2_side;

   sei_div #(
      .NUM_W  (N2_W),
      .DEN_W  (DW),
      .Q_W    (Q_W),
      .SIDE_W (CTX_W)
   ) u_div_frac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_num    (p2_num_ff),
      .in_den    (ee),
      .in_side   (p2_ctx_ff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   // M1: clamp F, magnitude of end - start
   ctx_type     d2_ctx;
   logic [32:0] ab;

   assign d2_ctx = ctx_type'(d2_side);
   assign ab     = {d2_ctx.b[31], d2_ctx.b} - {d2_ctx.a[31], d2_ctx.a};

   logic        m1_valid_ff;
   ctx_type     m1_ctx_ff;
   logic [30:0] m1_f_ff;
   logic [32:0] m1_mag_ff;
   logic        m1_neg_ff;

   // M2: two partial products
   logic        m2_valid_ff;
   ctx_type     m2_ctx_ff;
   logic        m2_neg_ff;
   logic [46:0] m2_lo_ff;
   logic [47:0] m2_hi_ff;

   // M3: round half away from zero, apply, saturate
   logic [63:0]        prod_sum;
   logic [33:0]        step_mag;
   logic signed [35:0] res_wide;
   logic [31:0]        m3_value_in;

   always_comb begin
      prod_sum = ({16'b0, m2_hi_ff} << 16) + {17'b0, m2_lo_ff} + (64'd1 << 29);
      step_mag = prod_sum[63:30];
      res_wide = m2_neg_ff ? ({{4{m2_ctx_ff.a[31]}}, m2_ctx_ff.a} - {2'b0, step_mag}) :
                             ({{4{m2_ctx_ff.a[31]}}, m2_ctx_ff.a} + {2'b0, step_mag});
      case (m2_ctx_ff.seg)
         sei_pkg::SEG_START: m3_value_in = m2_ctx_ff.a;
         sei_pkg::SEG_END:   m3_value_in = m2_ctx_ff.b;
         default: begin
            if (res_wide > SAT_MAX) begin
               m3_value_in = SAT_MAX[31:0];
            end else if (res_wide < SAT_MIN) begin
               m3_value_in = SAT_MIN[31:0];
            end else begin
               m3_value_in = res_wide[31:0];
            end
         end
      endcase
   end

   logic        m3_valid_ff;
   logic [31:0] m3_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= d2_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ctx_ff   <= d2_ctx;
         m1_f_ff     <= (d2_quot > F_ONE) ? F_ONE : d2_quot;
         m1_mag_ff   <= ab[32] ? -ab : ab;
         m1_neg_ff   <= ab[32];
         m2_ctx_ff   <= m1_ctx_ff;
         m2_neg_ff   <= m1_neg_ff;
         m2_lo_ff    <= m1_mag_ff[15:0] * m1_f_ff;
         m2_hi_ff    <= m1_mag_ff[32:16] * m1_f_ff;
         m3_value_ff <= m3_value_in;
      end
   end

   assign rsp_valid       = m3_valid_ff;
   assign rsp_eased_value = m3_value_ff;

   // no result survives a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // progress of one gives the end value exactly
   assert property (@(posedge clock) disable iff (reset)
      (m2_valid_ff && en && m2_ctx_ff.seg == sei_pkg::SEG_END)
      |=> (rsp_eased_value == $past(m2_ctx_ff.b)))
      else $error("end segment did not return the end value");

   // second divider only sees numerators whose quotient fits
   assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && (p2_ctx_ff.seg == sei_pkg::SEG_IN ||
                       p2_ctx_ff.seg == sei_pkg::SEG_MID ||
                       p2_ctx_ff.seg == sei_pkg::SEG_OUT))
      |-> ((p2_num_ff >> Q_W) < N2_W'(ee)))
      else $error("fraction numerator out of divider range");

endmodule

`default_nettype wire

// File: src/sei_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels alongside. Standalone; no package use.
`default_nettype none

module sei_div #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 18,
   parameter int Q_W    = 31,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [Q_W-1:0]         out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   // caller guarantees in_num < in_den * 2^Q_W, so the top part fits
   localparam int HI_W = NUM_W - Q_W;

   logic              valid_ff [0:Q_W-1];
   logic [DEN_W-1:0]  rem_ff   [0:Q_W-1];
   logic [Q_W-1:0]    low_ff   [0:Q_W-1];
   logic [Q_W-1:0]    quot_ff  [0:Q_W-1];
   logic [DEN_W-1:0]  den_ff   [0:Q_W-1];
   logic [SIDE_W-1:0] side_ff  [0:Q_W-1];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic              valid_src;
      logic [DEN_W-1:0]  rem_src;
      logic [Q_W-1:0]    low_src;
      logic [Q_W-1:0]    quot_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              fits;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = DEN_W'(in_num[NUM_W-1 -: HI_W]);
         assign low_src   = in_num[Q_W-1:0];
         assign quot_src  = '0;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign low_src   = low_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign den_src   = den_ff[j-1];
         assign side_src  = side_ff[j-1];
      end

      assign trial = {rem_src, low_src[Q_W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign fits  = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[j]  <= low_src << 1;
            quot_ff[j] <= {quot_src[Q_W-2:0], fits};
            den_ff[j]  <= den_src;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

`default_nettype wire

// File: src/sei_sine.sv
// Three-stage sin(pi u)/pi evaluator: fold, table read, linear interpolation.
// Uses sei_pkg for the table entry function.
`default_nettype none

module sei_sine #(
   parameter int TABLE_BITS = 10,
   parameter int SIDE_W     = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [30:0]                in_u,
   input  wire logic [SIDE_W-1:0]          in_side,
   output logic                            out_valid,
   output logic [30:0]                     out_u,
   output logic [sei_pkg::SINE_W-1:0]      out_sin,
   output logic [SIDE_W-1:0]               out_side
);

   localparam int SW      = sei_pkg::SINE_W;
   localparam int IW      = TABLE_BITS + 1;
   localparam int SH      = 29 - TABLE_BITS;
   localparam int TAB_LEN = (1 << TABLE_BITS) + 1;
   localparam logic [IW-1:0] STEPS    = IW'(1) << TABLE_BITS;
   localparam logic [30:0]   Q30_ONE  = 31'h4000_0000;
   localparam logic [30:0]   Q30_HALF = 31'h2000_0000;

   logic [SW-1:0] sine_rom [0:TAB_LEN-1];

   for (genvar i = 0; i < TAB_LEN; i++) begin : g_rom
      assign sine_rom[i] = sei_pkg::sine_entry(i, TABLE_BITS);
   end

   // stage A: fold and read both neighbors
   logic [30:0]   u_sat;
   logic [29:0]   u_fold;
   logic [IW-1:0] idx;
   logic [IW-1:0] idx_hi;

   assign u_sat  = (in_u > Q30_ONE) ? Q30_ONE : in_u;
   assign u_fold = (u_sat > Q30_HALF) ? 30'(Q30_ONE - u_sat) : u_sat[29:0];
   assign idx    = u_fold[29:SH];
   assign idx_hi = (idx == STEPS) ? idx : idx + 1'b1;

   logic              a_valid_ff;
   logic [30:0]       a_u_ff;
   logic [SIDE_W-1:0] a_side_ff;
   logic [SW-1:0]     a_lo_ff;
   logic [SW-1:0]     a_hi_ff;
   logic [SH-1:0]     a_frac_ff;

   // stage B: slope times fraction
   logic [SW:0]       diff;
   logic [SW-1:0]     diff_mag;
   logic [SW+SH-1:0]  b_prod_in;

   assign diff      = {1'b0, a_hi_ff} - {1'b0, a_lo_ff};
   assign diff_mag  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
   assign b_prod_in = diff_mag * a_frac_ff;

   logic              b_valid_ff;
   logic [30:0]       b_u_ff;
   logic [SIDE_W-1:0] b_side_ff;
   logic [SW-1:0]     b_lo_ff;
   logic              b_neg_ff;
   logic [SW+SH-1:0]  b_prod_ff;

   // stage C: truncate toward the lower entry
   logic [SW-1:0] step;
   logic [SW-1:0] c_sin_in;

   assign step     = b_prod_ff[SW+SH-1:SH];
   assign c_sin_in = b_neg_ff ? b_lo_ff - step : b_lo_ff + step;

   logic              c_valid_ff;
   logic [30:0]       c_u_ff;
   logic [SIDE_W-1:0] c_side_ff;
   logic [SW-1:0]     c_sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_u_ff    <= in_u;
         a_side_ff <= in_side;
         a_lo_ff   <= sine_rom[idx];
         a_hi_ff   <= sine_rom[idx_hi];
         a_frac_ff <= u_fold[SH-1:0];
         b_u_ff    <= a_u_ff;
         b_side_ff <= a_side_ff;
         b_lo_ff   <= a_lo_ff;
         b_neg_ff  <= diff[SW];
         b_prod_ff <= b_prod_in;
         c_u_ff    <= b_u_ff;
         c_side_ff <= b_side_ff;
         c_sin_ff  <= c_sin_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_u     = c_u_ff;
   assign out_sin   = c_sin_ff;
   assign out_side  = c_side_ff;

endmodule

`default_nettype wire
